@@ src/cia_pkg.sv @@
// ----------------------------------------------------------------------------
// cia_pkg
// Opcode and status codes and the word that moves along the divider row.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned DW = 64;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0,
    FN_SUB = 4'd1,
    FN_MUL = 4'd2,
    FN_DIV = 4'd3,
    FN_MOD = 4'd4,
    FN_EQ  = 4'd5,
    FN_NE  = 4'd6,
    FN_LT  = 4'd7,
    FN_GT  = 4'd8,
    FN_LE  = 4'd9,
    FN_GE  = 4'd10
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [3:0]    func;
    logic          neg_a;
    logic          neg_b;
    logic [DW-1:0] divisor;
    logic [DW-1:0] rem;
    logic [DW-1:0] quo;
    logic [DW-1:0] value;
    status_t       status;
  } cell_t;

endpackage

@@ src/cia_prep.sv @@
// ----------------------------------------------------------------------------
// cia_prep
// Front stages: add, subtract and compare, operand magnitudes, a split
// multiplier over two stages, and the divider row's first word.
// ----------------------------------------------------------------------------
module cia_prep import cia_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          in_valid,
  input  logic [3:0]    in_func,
  input  logic [DW-1:0] in_operand_a,
  input  logic [DW-1:0] in_operand_b,
  output logic          vld_out,
  output cell_t         d_out
);

  logic [DW-1:0] sum, dif, ua, ub, val0;
  status_t       st0;
  logic          lt_ab, lt_ba;

  always_comb begin
    sum   = in_operand_a + in_operand_b;
    dif   = in_operand_a - in_operand_b;
    ua    = in_operand_a[DW-1] ? (~in_operand_a + 1'b1) : in_operand_a;
    ub    = in_operand_b[DW-1] ? (~in_operand_b + 1'b1) : in_operand_b;
    lt_ab = $signed(in_operand_a) < $signed(in_operand_b);
    lt_ba = $signed(in_operand_b) < $signed(in_operand_a);
    val0  = '0;
    st0   = ST_OK;
    case (func_t'(in_func))
      FN_ADD: begin
        if (((in_operand_a[DW-1] == in_operand_b[DW-1]) &&
             (sum[DW-1] != in_operand_a[DW-1])) || sum == MIN_VAL) st0 = ST_OVF;
        else val0 = sum;
      end
      FN_SUB: begin
        if (((in_operand_a[DW-1] != in_operand_b[DW-1]) &&
             (dif[DW-1] != in_operand_a[DW-1])) || dif == MIN_VAL) st0 = ST_OVF;
        else val0 = dif;
      end
      FN_EQ: val0 = {{(DW-1){1'b0}}, in_operand_a == in_operand_b};
      FN_NE: val0 = {{(DW-1){1'b0}}, in_operand_a != in_operand_b};
      FN_LT: val0 = {{(DW-1){1'b0}}, lt_ab};
      FN_GT: val0 = {{(DW-1){1'b0}}, lt_ba};
      FN_LE: val0 = {{(DW-1){1'b0}}, ~lt_ba};
      FN_GE: val0 = {{(DW-1){1'b0}}, ~lt_ab};
      default: ;
    endcase
  end

  // stage 0
  logic          s0_vld_r;
  logic [3:0]    s0_func_r;
  logic          s0_na_r, s0_nb_r;
  logic [DW-1:0] s0_ua_r, s0_ub_r, s0_val_r;
  status_t       s0_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (advance) s0_vld_r <= in_valid;
    if (advance) begin
      s0_func_r <= in_func;
      s0_na_r   <= in_operand_a[DW-1];
      s0_nb_r   <= in_operand_b[DW-1];
      s0_ua_r   <= ua;
      s0_ub_r   <= ub;
      s0_val_r  <= val0;
      s0_st_r   <= st0;
    end
  end

  // stage 1: partial products
  logic          s1_vld_r;
  logic [3:0]    s1_func_r;
  logic          s1_na_r, s1_nb_r;
  logic [DW-1:0] s1_ua_r, s1_ub_r, s1_val_r;
  status_t       s1_st_r;
  logic [DW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (advance) s1_vld_r <= s0_vld_r;
    if (advance) begin
      s1_func_r <= s0_func_r;
      s1_na_r   <= s0_na_r;
      s1_nb_r   <= s0_nb_r;
      s1_ua_r   <= s0_ua_r;
      s1_ub_r   <= s0_ub_r;
      s1_val_r  <= s0_val_r;
      s1_st_r   <= s0_st_r;
      pp00_r    <= s0_ua_r[31:0]  * s0_ub_r[31:0];
      pp01_r    <= s0_ua_r[31:0]  * s0_ub_r[63:32];
      pp10_r    <= s0_ua_r[63:32] * s0_ub_r[31:0];
      pp11_r    <= s0_ua_r[63:32] * s0_ub_r[63:32];
    end
  end

  // stage 2: sum partials, range check, set up divider word
  logic [2*DW-1:0] prod;
  cell_t           c_nxt;

  always_comb begin
    prod = {{DW{1'b0}}, pp00_r} + {32'd0, pp01_r, 32'd0} +
           {32'd0, pp10_r, 32'd0} + {pp11_r, {DW{1'b0}}};
    c_nxt.func    = s1_func_r;
    c_nxt.neg_a   = s1_na_r;
    c_nxt.neg_b   = s1_nb_r;
    c_nxt.divisor = s1_ub_r;
    c_nxt.rem     = '0;
    c_nxt.quo     = s1_ua_r;
    c_nxt.value   = s1_val_r;
    c_nxt.status  = s1_st_r;
    case (func_t'(s1_func_r))
      FN_MUL: begin
        if (prod[2*DW-1:DW-1] != '0) c_nxt.status = ST_OVF;
        else if (s1_na_r != s1_nb_r) c_nxt.value = ~prod[DW-1:0] + 1'b1;
        else c_nxt.value = prod[DW-1:0];
      end
      FN_DIV, FN_MOD: begin
        if (s1_ub_r == '0) c_nxt.status = ST_DIV0;
      end
      default: ;
    endcase
  end

  logic  vld_r;
  cell_t d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (advance) vld_r <= s1_vld_r;
    if (advance) d_r <= c_nxt;
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

@@ src/cia_div_cell.sv @@
// ----------------------------------------------------------------------------
// cia_div_cell
// One restoring divider cell: retires one quotient bit per word.
// ----------------------------------------------------------------------------
module cia_div_cell import cia_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  logic  vld_in,
  input  cell_t d_in,
  output logic  vld_out,
  output cell_t d_out
);

  logic [DW:0] shifted, trial;
  cell_t       d_nxt;

  always_comb begin
    shifted = {d_in.rem, d_in.quo[DW-1]};
    trial   = shifted - {1'b0, d_in.divisor};
    d_nxt   = d_in;
    if (!trial[DW]) begin
      d_nxt.rem = trial[DW-1:0];
      d_nxt.quo = {d_in.quo[DW-2:0], 1'b1};
    end else begin
      d_nxt.rem = shifted[DW-1:0];
      d_nxt.quo = {d_in.quo[DW-2:0], 1'b0};
    end
  end

  logic  vld_r;
  cell_t d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (advance) vld_r <= vld_in;
    if (advance) d_r <= d_nxt;
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

@@ src/checked_integer_alu.sv @@
// Pipeline: 3 front stages, 64 divider cells and 1 output register lie
// between an accepted input word and its output word, for every opcode.
// Throughput: one word per cycle; the whole pipe holds while the output
// word waits, set by the single-bit-per-cell divider row.
// Reset: synchronous active-low rst_n clears all valid flags.
// ----------------------------------------------------------------------------
// checked_integer_alu
// Overflow-checked 64-bit integer ALU built around a row of divider cells.
// ----------------------------------------------------------------------------
module checked_integer_alu import cia_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [3:0]    in_func,
  input  logic [DW-1:0] in_operand_a,
  input  logic [DW-1:0] in_operand_b,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_value,
  output logic [1:0]    out_status
);

  logic  advance;
  logic  vld [0:DW];
  cell_t chain [0:DW];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  cia_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .in_valid     (in_valid),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .vld_out      (vld[0]),
    .d_out        (chain[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    cia_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .vld_in  (vld[i]),
      .d_in    (chain[i]),
      .vld_out (vld[i+1]),
      .d_out   (chain[i+1])
    );
  end

  cell_t         last;
  logic [DW-1:0] val_nxt;
  status_t       st_nxt;

  always_comb begin
    last    = chain[DW];
    val_nxt = last.value;
    st_nxt  = last.status;
    if (last.status == ST_OK) begin
      case (func_t'(last.func))
        FN_DIV: begin
          if (last.quo[DW-1]) begin
            st_nxt  = ST_OVF;
            val_nxt = '0;
          end else if (last.neg_a != last.neg_b) val_nxt = ~last.quo + 1'b1;
          else val_nxt = last.quo;
        end
        FN_MOD: val_nxt = last.neg_a ? (~last.rem + 1'b1) : last.rem;
        default: ;
      endcase
    end
  end

  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  status_t       out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (advance) out_valid_r <= vld[DW];
    if (advance) begin
      out_value_r  <= val_nxt;
      out_status_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

@@ src/cia_checker.sv @@
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks for the ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker import cia_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [DW-1:0] out_value,
  input logic [1:0]    out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("output word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_OVF || out_status == ST_DIV0)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("nonzero value with error status");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value != MIN_VAL)
    else $error("minimum value delivered");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled with free output");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .out_status (out_status)
);
